>>> src/assert_macros.svh
// Assertion macros used by the agent top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define TQLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqla assertion failed");

// Check a condition in the cycle after its trigger.
`define TQLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqla assertion failed");

`endif

>>> src/tqla_pkg.sv
// Shared types, constants and helpers of the Q-learning agent.
package tqla_pkg;

    localparam int STATE_COUNT = 1024;               // power of two
    localparam int STATE_W     = $clog2(STATE_COUNT);
    localparam int NUM_ACT     = 4;
    localparam int UTIL_W      = 32;
    localparam int VISIT_W     = 30;
    localparam int DIV_W       = 32;

    localparam logic [VISIT_W-1:0] VISIT_MAX = 30'd999999999;

    localparam logic [15:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST   = 16'd58982;

    localparam logic CFG_LEARN_RATE = 1'b0;
    localparam logic CFG_DISCOUNT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_CHOOSE      = 2'd0,
        CMD_OBSERVE     = 2'd1,
        CMD_CORRECT     = 2'd2,
        CMD_NEW_EPISODE = 2'd3
    } t_cmd;

    function automatic logic signed [UTIL_W-1:0] sat_q16(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -37'sd2147483648)
            return 32'sh80000000;
        else
            return v[UTIL_W-1:0];
    endfunction

endpackage

>>> src/tqla_div.sv
// Iterative unsigned remainder unit, one quotient bit per cycle.
module tqla_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tqla_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tqla_pkg::DIV_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [tqla_pkg::DIV_W-1:0]  o_rem
);
    import tqla_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            // remainder stays below the divisor, so it fits after the subtract
            if (trial >= {1'b0, r_den})
                r_rem <= diff[DIV_W-1:0];
            else
                r_rem <= trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> src/tabular_q_learning_agent.sv
// Top level of the tabular Q-learning agent with count-based exploration.
//
// Input items arrive on the s_axis channel, one command each (choose,
// observe, correct, new episode); each gives exactly one result item on
// the m_axis channel. The learn rate and discount registers are written
// through the cfg channel, which is always ready; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// One item is processed at a time; s_axis_tready is high only while idle.
// Choose takes two remainder runs on the shared divider (none when no move
// is valid); observe takes two memory reads and two registered multiplies.
// Utilities and visit counts live in two row memories of STATE_COUNT rows,
// four actions per row, read through a registered output and written back.
// After reset a clearing pass zeroes one row per cycle, all STATE_COUNT
// (1024) rows, before the first item is accepted.
// A finished result waits in the output register while m_axis_tready is
// low; the next item is accepted meanwhile, and its result waits for that
// register to empty.
`include "assert_macros.svh"
module tabular_q_learning_agent (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command[1:0], state_index[11:2], valid_moves[15:12], reward[47:16],
    // random_explore[79:48], random_pick[111:80]
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // chosen_action[1:0], was_random[2], new_utility[34:3],
    // random_count[66:35], total_count[98:67], zero[103:99]
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import tqla_pkg::*;

    localparam int UROW_W = NUM_ACT * UTIL_W;
    localparam int VROW_W = NUM_ACT * VISIT_W;

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_DISP    = 14'b00000000000100,
        ST_CH_EVAL = 14'b00000000001000,
        ST_CH_DIV1 = 14'b00000000010000,
        ST_CH_DIV2 = 14'b00000000100000,
        ST_OB_EVAL = 14'b00000001000000,
        ST_OB_MUL1 = 14'b00000010000000,
        ST_OB_SUM  = 14'b00000100000000,
        ST_OB_MUL2 = 14'b00001000000000,
        ST_OB_UPD  = 14'b00010000000000,
        ST_CR_MUL  = 14'b00100000000000,
        ST_CR_UPD  = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } t_state;

    t_state r_state;

    // memories
    logic [UROW_W-1:0]  r_umem [STATE_COUNT];
    logic [VROW_W-1:0]  r_vmem [STATE_COUNT];
    logic [UROW_W-1:0]  r_urd;
    logic [VROW_W-1:0]  r_vrd;
    logic               u_re, v_re, u_we, v_we;
    logic [STATE_W-1:0] u_raddr, u_waddr, v_waddr;
    logic [UROW_W-1:0]  u_wdata;
    logic [VROW_W-1:0]  v_wdata;
    logic [STATE_W-1:0] r_clr_idx;

    // captured item
    t_cmd               r_cmd;
    logic [STATE_W-1:0] r_s;
    logic [3:0]         r_mask;
    logic signed [31:0] r_reward;
    logic [31:0]        r_rex;
    logic [31:0]        r_rpk;

    // configuration and episode state
    logic [15:0]        r_alpha, r_gamma;
    logic [STATE_W-1:0] r_cur_state, r_last_state;
    logic               r_have_cur, r_have_last;
    logic [1:0]         r_cur_act, r_last_act, r_tent_act;
    logic               r_rflag;
    logic [31:0]        r_rand_cnt, r_tot_cnt;

    // working registers
    logic [1:0]          r_act;
    logic                r_rnd;
    logic signed [31:0]  r_nu;
    logic signed [31:0]  r_qmax, r_q;
    logic signed [34:0]  r_delta;
    logic signed [51:0]  r_prod;
    logic [3:0][1:0]     r_list, r_ties;
    logic [2:0]          r_n, r_m;
    logic                r_pick_rand;

    // choose evaluation
    logic [VISIT_W-1:0]  c_minv, c_v;
    logic                c_any, c_bany;
    logic [2:0]          c_n, c_m;
    logic [3:0][1:0]     c_list, c_ties;
    logic signed [31:0]  c_best, c_u;

    // arithmetic
    logic signed [48:0]  prod_g, prod_c;
    logic signed [51:0]  prod_a;
    logic signed [36:0]  upd_sum;
    logic signed [31:0]  upd_val;

    // divider
    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dividend, div_divisor, div_rem;

    logic                in_acc, out_free;
    logic [VISIT_W-1:0]  vis_old;
    logic                st_wr_ok, st_div_ok, out_load;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    always_comb begin
        c_minv = '0;
        c_any  = 1'b0;
        c_n    = '0;
        c_list = '0;
        c_best = '0;
        c_bany = 1'b0;
        c_m    = '0;
        c_ties = '0;
        c_v    = '0;
        c_u    = '0;
        for (int a = 0; a < NUM_ACT; a++) begin
            if (r_mask[a]) begin
                c_v = r_vrd[a*VISIT_W +: VISIT_W];
                c_u = r_urd[a*UTIL_W +: UTIL_W];
                if (!c_any || c_v < c_minv)
                    c_minv = c_v;
                if (!c_bany || c_u > c_best)
                    c_best = c_u;
                c_any = 1'b1;
                c_bany = 1'b1;
                c_list[c_n[1:0]] = 2'(a);
                c_n = c_n + 3'd1;
            end
        end
        for (int a = 0; a < NUM_ACT; a++) begin
            if (r_mask[a] && $signed(r_urd[a*UTIL_W +: UTIL_W]) == c_best) begin
                c_ties[c_m[1:0]] = 2'(a);
                c_m = c_m + 3'd1;
            end
        end
    end

    assign prod_g  = $signed({1'b0, r_gamma}) * r_qmax;
    assign prod_c  = $signed({1'b0, r_alpha}) * r_reward;
    assign prod_a  = $signed({1'b0, r_alpha}) * r_delta;
    // the shifts below round toward minus infinity
    assign upd_sum = 37'(r_q) + 37'($signed(r_prod[51:16]));
    assign upd_val = sat_q16(upd_sum);
    assign vis_old = r_vrd[r_tent_act*VISIT_W +: VISIT_W];

    // memory port control
    always_comb begin
        u_re    = (r_state == ST_DISP) || (r_state == ST_OB_EVAL);
        v_re    = (r_state == ST_DISP);
        u_raddr = r_s;
        if (r_state == ST_OB_EVAL)
            u_raddr = r_cur_state;
        else if (r_cmd == CMD_CORRECT)
            u_raddr = r_last_state;
        u_we    = 1'b0;
        u_waddr = r_cur_state;
        u_wdata = r_urd;
        v_we    = 1'b0;
        v_waddr = r_s;
        v_wdata = r_vrd;
        case (r_state)
            ST_CLEAR: begin
                u_we    = 1'b1;
                u_waddr = r_clr_idx;
                u_wdata = '0;
                v_we    = 1'b1;
                v_waddr = r_clr_idx;
                v_wdata = '0;
            end
            ST_OB_UPD: begin
                u_we = r_have_cur;
                u_wdata[r_cur_act*UTIL_W +: UTIL_W] = upd_val;
                v_we = 1'b1;
                if (vis_old < VISIT_MAX)
                    v_wdata[r_tent_act*VISIT_W +: VISIT_W] = vis_old + 1'b1;
            end
            ST_CR_UPD: begin
                u_we    = r_have_last;
                u_waddr = r_last_state;
                u_wdata[r_last_act*UTIL_W +: UTIL_W] = upd_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (u_we)
            r_umem[u_waddr] <= u_wdata;
        if (u_re)
            r_urd <= r_umem[u_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we)
            r_vmem[v_waddr] <= v_wdata;
        if (v_re)
            r_vrd <= r_vmem[r_s];
    end

    // divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_rpk;
        div_divisor  = 32'(r_m);
        case (r_state)
            ST_CH_EVAL: begin
                div_start    = (r_mask != 4'd0);
                div_dividend = r_rex;
                div_divisor  = 32'(c_minv) + 32'd1;
            end
            ST_CH_DIV1: begin
                div_start = div_done;
                if (div_rem == '0)
                    div_divisor = 32'(r_n);
            end
            default: begin
            end
        endcase
    end

    tqla_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= LEARN_RATE_RST;
            r_gamma <= DISCOUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEARN_RATE: r_alpha <= i_cfg_data;
                CFG_DISCOUNT:   r_gamma <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and episode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_cur_state   <= '0;
            r_last_state  <= '0;
            r_have_cur    <= 1'b0;
            r_have_last   <= 1'b0;
            r_cur_act     <= '0;
            r_last_act    <= '0;
            r_tent_act    <= '0;
            r_rflag       <= 1'b1;
            r_rand_cnt    <= '0;
            r_tot_cnt     <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == STATE_W'(STATE_COUNT - 1))
                        r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (in_acc)
                        r_state <= ST_DISP;
                end
                ST_DISP: begin
                    case (r_cmd)
                        CMD_CHOOSE:  r_state <= ST_CH_EVAL;
                        CMD_OBSERVE: r_state <= ST_OB_EVAL;
                        CMD_CORRECT: r_state <= ST_CR_MUL;
                        default:     r_state <= ST_DONE;
                    endcase
                end
                ST_CH_EVAL: begin
                    if (r_mask == 4'd0) begin
                        r_rflag    <= 1'b0;
                        r_tent_act <= '0;
                        r_state    <= ST_DONE;
                    end else begin
                        r_state <= ST_CH_DIV1;
                    end
                end
                ST_CH_DIV1: begin
                    if (div_done)
                        r_state <= ST_CH_DIV2;
                end
                ST_CH_DIV2: begin
                    if (div_done) begin
                        r_rflag    <= r_pick_rand;
                        r_tent_act <= r_pick_rand ? r_list[div_rem[1:0]]
                                                  : r_ties[div_rem[1:0]];
                        r_state    <= ST_DONE;
                    end
                end
                ST_OB_EVAL: r_state <= ST_OB_MUL1;
                ST_OB_MUL1: r_state <= ST_OB_SUM;
                ST_OB_SUM:  r_state <= ST_OB_MUL2;
                ST_OB_MUL2: r_state <= ST_OB_UPD;
                ST_OB_UPD: begin
                    r_last_state <= r_cur_state;
                    r_have_last  <= r_have_cur;
                    r_cur_state  <= r_s;
                    r_have_cur   <= 1'b1;
                    r_last_act   <= r_cur_act;
                    r_cur_act    <= r_tent_act;
                    if (r_rflag)
                        r_rand_cnt <= r_rand_cnt + 32'd1;
                    r_tot_cnt <= r_tot_cnt + 32'd1;
                    r_state   <= ST_DONE;
                end
                ST_CR_MUL: r_state <= ST_CR_UPD;
                ST_CR_UPD: r_state <= ST_DONE;
                ST_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_axis_tvalid <= 1'b1;
                        r_state       <= ST_IDLE;
                        if (r_cmd == CMD_NEW_EPISODE) begin
                            r_cur_state  <= '0;
                            r_last_state <= '0;
                            r_have_cur   <= 1'b0;
                            r_have_last  <= 1'b0;
                            r_cur_act    <= '0;
                            r_last_act   <= '0;
                            r_tent_act   <= '0;
                            r_rflag      <= 1'b1;
                            r_rand_cnt   <= '0;
                            r_tot_cnt    <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= t_cmd'(s_axis_tdata[1:0]);
            r_s      <= s_axis_tdata[2 +: STATE_W];
            r_mask   <= s_axis_tdata[15:12];
            r_reward <= s_axis_tdata[47:16];
            r_rex    <= s_axis_tdata[79:48];
            r_rpk    <= s_axis_tdata[111:80];
        end
        case (r_state)
            ST_DISP: begin
                r_act <= '0;
                r_rnd <= 1'b0;
                r_nu  <= '0;
            end
            ST_CH_EVAL: begin
                r_list <= c_list;
                r_ties <= c_ties;
                r_n    <= c_n;
                r_m    <= c_m;
            end
            ST_CH_DIV1: begin
                if (div_done)
                    r_pick_rand <= (div_rem == '0);
            end
            ST_CH_DIV2: begin
                if (div_done) begin
                    r_act <= r_pick_rand ? r_list[div_rem[1:0]] : r_ties[div_rem[1:0]];
                    r_rnd <= r_pick_rand;
                end
            end
            ST_OB_EVAL: begin
                r_qmax <= c_bany ? c_best : 32'sd0;
            end
            ST_OB_MUL1: begin
                r_q    <= r_urd[r_cur_act*UTIL_W +: UTIL_W];
                r_prod <= 52'(prod_g);
            end
            ST_OB_SUM: begin
                r_delta <= 35'(r_reward) + 35'($signed(r_prod[48:16])) - 35'(r_q);
            end
            ST_OB_MUL2: begin
                r_prod <= prod_a;
            end
            ST_OB_UPD: begin
                r_nu  <= r_have_cur ? upd_val : 32'sd0;
                r_act <= r_tent_act;
                r_rnd <= r_rflag;
            end
            ST_CR_MUL: begin
                r_q    <= r_urd[r_last_act*UTIL_W +: UTIL_W];
                r_prod <= 52'(prod_c);
            end
            ST_CR_UPD: begin
                r_nu <= r_have_last ? upd_val : 32'sd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free)
            m_axis_tdata <= {5'd0, r_tot_cnt, r_rand_cnt, r_nu, r_rnd, r_act};
    end

    assign st_wr_ok  = (r_state == ST_OB_UPD) || (r_state == ST_CR_UPD) ||
                       (r_state == ST_CLEAR);
    assign st_div_ok = (r_state == ST_CH_DIV1) || (r_state == ST_CH_DIV2);
    assign out_load  = (r_state == ST_DONE) && out_free;

    `TQLA_ASSERT_SAME(a_uwr_state, i_clk, i_rst_n, u_we, st_wr_ok)
    `TQLA_ASSERT_SAME(a_div_wait, i_clk, i_rst_n, div_done, st_div_ok)
    `TQLA_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, (m_axis_tvalid && r_state == ST_IDLE))

endmodule
